>>> rtl/eamc_pkg.sv
// Shared types and constants for the encoder axis move controller.
package eamc_pkg;

    // Command codes
    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_START  = 2'd1;
    localparam logic [1:0] CMD_STOP   = 2'd2;
    localparam logic [1:0] CMD_HOME   = 2'd3;

    // Move status codes
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_MOVING   = 3'd1;
    localparam logic [2:0] ST_REACHED  = 3'd2;
    localparam logic [2:0] ST_ALREADY  = 3'd3;
    localparam logic [2:0] ST_STALLED  = 3'd4;
    localparam logic [2:0] ST_TIMEOUT  = 3'd5;
    localparam logic [2:0] ST_STOPPED  = 3'd6;

    // Configuration register indexes
    localparam logic [2:0] REG_MAX_DUTY    = 3'd0;
    localparam logic [2:0] REG_MIN_DUTY    = 3'd1;
    localparam logic [2:0] REG_STALL_LIMIT = 3'd2;
    localparam logic [2:0] REG_TIMEOUT     = 3'd3;
    localparam logic [2:0] REG_INVERT      = 3'd4;

    // Configuration reset values
    localparam logic [7:0]  MAX_DUTY_RST    = 8'd150;
    localparam logic [7:0]  MIN_DUTY_RST    = 8'd45;
    localparam logic [15:0] STALL_LIMIT_RST = 16'd400;
    localparam logic [15:0] TIMEOUT_RST     = 16'd8000;

    // Bridge pin patterns {drive_a, drive_b}
    localparam logic [1:0] PINS_FORWARD = 2'b10;
    localparam logic [1:0] PINS_REVERSE = 2'b01;
    localparam logic [1:0] PINS_BRAKE   = 2'b11;

    typedef struct packed {
        logic [1:0]         cmd;
        logic               hall_a;
        logic               hall_b;
        logic               ms_tick;
        logic signed [31:0] target_count;
        logic [7:0]         duty_request;
    } in_item_t;

    typedef struct packed {
        logic               drive_a;
        logic               drive_b;
        logic [7:0]         duty;
        logic signed [31:0] position;
        logic [2:0]         status;
    } out_item_t;

endpackage

>>> rtl/encoder_axis_move_controller_top.sv
// Encoder axis move controller: hall decode, move sequencing, stall and timeout.
//
// One transaction in gives one transaction out. Each item is captured in an
// input register, processed by combinational logic against the axis state,
// and the result lands in an output register, so the block sustains one item
// per clock; the only thing that slows it is the result side withholding
// m_ready. Configuration writes take effect on the cycle after the write and
// cfg_ready is always high.
module encoder_axis_move_controller_top #(
    parameter int COUNT_WIDTH = 32,
    parameter int TIMER_WIDTH = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  eamc_pkg::in_item_t s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output eamc_pkg::out_item_t m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import eamc_pkg::*;

    localparam int CMP_W = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;
    localparam int EXT_W = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

    // Configuration registers
    logic [7:0]  max_duty_reg, min_duty_reg;
    logic [15:0] stall_limit_reg, timeout_reg;
    logic        invert_reg;

    // Pipeline registers
    logic      in_valid_reg, out_valid_reg;
    in_item_t  in_item_reg;
    out_item_t out_item_reg, out_item_next;

    // Axis state
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [COUNT_WIDTH-1:0] goal_reg, goal_next;
    logic [COUNT_WIDTH-1:0] seen_reg, seen_next;
    logic [TIMER_WIDTH-1:0] still_reg, still_next;
    logic [TIMER_WIDTH-1:0] move_reg, move_next;
    logic                   prev_a_reg, prev_a_next;
    logic                   running_reg, running_next;
    logic                   fwd_reg, fwd_next;
    logic [1:0]             pins_reg, pins_next;
    logic [7:0]             duty_reg, duty_next;
    logic [2:0]             status_reg, status_next;

    logic advance;
    logic [COUNT_WIDTH-1:0] dec_count, target;
    logic [EXT_W-1:0]       target_ext, pos_ext;
    logic [7:0]             duty_clamp;
    logic                   reached;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_item_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_duty_reg    <= MAX_DUTY_RST;
            min_duty_reg    <= MIN_DUTY_RST;
            stall_limit_reg <= STALL_LIMIT_RST;
            timeout_reg     <= TIMEOUT_RST;
            invert_reg      <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MAX_DUTY:    max_duty_reg    <= cfg_data[7:0];
                REG_MIN_DUTY:    min_duty_reg    <= cfg_data[7:0];
                REG_STALL_LIMIT: stall_limit_reg <= cfg_data[15:0];
                REG_TIMEOUT:     timeout_reg     <= cfg_data[15:0];
                REG_INVERT:      invert_reg      <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Hall decode on the captured item
    always_comb begin
        dec_count = count_reg;
        if (in_item_reg.hall_a != prev_a_reg) begin
            if (in_item_reg.hall_b != in_item_reg.hall_a) begin
                dec_count = count_reg + COUNT_WIDTH'(1);
            end else begin
                dec_count = count_reg - COUNT_WIDTH'(1);
            end
        end
    end

    // Target sign-extended then wrapped to the count width
    assign target_ext = EXT_W'(in_item_reg.target_count);
    assign target     = target_ext[COUNT_WIDTH-1:0];

    assign reached = fwd_reg ? ($signed(dec_count) >= $signed(goal_reg))
                             : ($signed(goal_reg) >= $signed(dec_count));

    // Duty clamp: cap at max, then lift nonzero values to min
    always_comb begin
        duty_clamp = (in_item_reg.duty_request > max_duty_reg) ? max_duty_reg
                                                              : in_item_reg.duty_request;
        if (duty_clamp != 8'd0 && duty_clamp < min_duty_reg) begin
            duty_clamp = min_duty_reg;
        end
    end

    // Per-item state update
    always_comb begin
        count_next   = count_reg;
        goal_next    = goal_reg;
        seen_next    = seen_reg;
        still_next   = still_reg;
        move_next    = move_reg;
        prev_a_next  = prev_a_reg;
        running_next = running_reg;
        fwd_next     = fwd_reg;
        pins_next    = pins_reg;
        duty_next    = duty_reg;
        status_next  = status_reg;
        case (in_item_reg.cmd)
            CMD_SAMPLE: begin
                count_next  = dec_count;
                prev_a_next = in_item_reg.hall_a;
                if (running_reg) begin
                    if (reached) begin
                        pins_next    = PINS_BRAKE;
                        duty_next    = 8'd0;
                        running_next = 1'b0;
                        status_next  = ST_REACHED;
                    end else begin
                        if (dec_count != seen_reg) begin
                            seen_next  = dec_count;
                            still_next = '0;
                        end else if (in_item_reg.ms_tick && still_reg != '1) begin
                            still_next = still_reg + TIMER_WIDTH'(1);
                        end
                        if (in_item_reg.ms_tick && move_reg != '1) begin
                            move_next = move_reg + TIMER_WIDTH'(1);
                        end
                        if (CMP_W'(still_next) > CMP_W'(stall_limit_reg)) begin
                            pins_next    = PINS_BRAKE;
                            duty_next    = 8'd0;
                            running_next = 1'b0;
                            status_next  = ST_STALLED;
                        end else if (CMP_W'(move_next) > CMP_W'(timeout_reg)) begin
                            pins_next    = PINS_BRAKE;
                            duty_next    = 8'd0;
                            running_next = 1'b0;
                            status_next  = ST_TIMEOUT;
                        end
                    end
                end
            end
            CMD_START: begin
                if (target == count_reg) begin
                    if (running_reg) begin
                        pins_next = PINS_BRAKE;
                        duty_next = 8'd0;
                    end
                    running_next = 1'b0;
                    status_next  = ST_ALREADY;
                end else begin
                    fwd_next     = $signed(target) >= $signed(count_reg);
                    pins_next    = (fwd_next ^ invert_reg) ? PINS_FORWARD : PINS_REVERSE;
                    duty_next    = duty_clamp;
                    goal_next    = target;
                    seen_next    = count_reg;
                    still_next   = '0;
                    move_next    = '0;
                    running_next = 1'b1;
                    status_next  = ST_MOVING;
                end
            end
            CMD_STOP: begin
                pins_next    = PINS_BRAKE;
                duty_next    = 8'd0;
                running_next = 1'b0;
                status_next  = ST_STOPPED;
            end
            default: begin
                count_next = '0;
            end
        endcase
    end

    // Result built from the updated state
    assign pos_ext = EXT_W'($signed(count_next));
    always_comb begin
        out_item_next.drive_a  = pins_next[1];
        out_item_next.drive_b  = pins_next[0];
        out_item_next.duty     = duty_next;
        out_item_next.position = pos_ext[31:0];
        out_item_next.status   = status_next;
    end

    // Handshake control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_data;
        end
        if (advance) begin
            out_item_reg <= out_item_next;
        end
    end

    // Axis state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            goal_reg    <= '0;
            seen_reg    <= '0;
            still_reg   <= '0;
            move_reg    <= '0;
            prev_a_reg  <= 1'b0;
            running_reg <= 1'b0;
            fwd_reg     <= 1'b0;
            pins_reg    <= '0;
            duty_reg    <= '0;
            status_reg  <= ST_IDLE;
        end else if (advance) begin
            count_reg   <= count_next;
            goal_reg    <= goal_next;
            seen_reg    <= seen_next;
            still_reg   <= still_next;
            move_reg    <= move_next;
            prev_a_reg  <= prev_a_next;
            running_reg <= running_next;
            fwd_reg     <= fwd_next;
            pins_reg    <= pins_next;
            duty_reg    <= duty_next;
            status_reg  <= status_next;
        end
    end

endmodule

>>> rtl/eamc_checker.sv
// Port-level checks for the encoder axis move controller, bound to the top level.
module eamc_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input eamc_pkg::out_item_t m_data
);
    import eamc_pkg::*;

    // A stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result payload changed while stalled");

    // Nonzero duty only appears during a move
    a_duty_moving: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.duty != 8'd0 |-> m_data.status == ST_MOVING)
        else $error("nonzero duty outside a move");

    // A move drives one bridge side only
    a_moving_pins: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_MOVING |-> m_data.drive_a != m_data.drive_b)
        else $error("moving without a drive direction");

    // Every ending other than already-there leaves the bridge braked
    a_end_brake: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == ST_REACHED || m_data.status == ST_STALLED ||
                    m_data.status == ST_TIMEOUT || m_data.status == ST_STOPPED)
        |-> m_data.drive_a && m_data.drive_b && m_data.duty == 8'd0)
        else $error("move ended without braking");

endmodule

bind encoder_axis_move_controller_top eamc_checker u_eamc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
